/* src/assert_macros.svh */
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define WTO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising clock edge, reset included
`define WTO_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/wto_pkg.sv */
// shared types, constants and helpers of the wavetable oscillator
package wto_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int ACC_W   = 26;
    localparam int FRAC_W  = 16;
    localparam int IPART_W = 10;
    localparam int SAMPLE_W = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 26;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 1'b1;
    localparam logic [IPART_W-1:0]   LENGTH_RESET     = 10'd256;

    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_LOAD      = 2'd1;
    localparam logic [1:0] OP_PHASE_RST = 2'd2;

    localparam logic [7:0] WEIGHT_MAX = 8'd255;

    // command queue between front and back
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // result buffer in the back end
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } cmd_kind_t;

    // tick: addr is the integer phase, data the interpolation weight
    // load: addr is the table position, data the sample
    typedef struct packed {
        cmd_kind_t           kind;
        logic [IPART_W-1:0]  addr;
        logic [SAMPLE_W-1:0] data;
    } cmd_t;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IPART_W-1:0] idx);
        to_addr = ADDR_W'(idx);
    endfunction

    function automatic logic [ADDR_W-1:0] next_addr(input logic [IPART_W-1:0] idx);
        logic [IPART_W:0] nxt;
        nxt = {1'b0, idx} + (IPART_W+1)'(1);
        next_addr = ADDR_W'(nxt);
    endfunction

endpackage

/* src/wto_ram.sv */
// generic single-port ram with registered read
module wto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/wto_cmd_queue.sv */
// short command queue between the front and back ends
module wto_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  wto_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output wto_pkg::cmd_t pop_data,
    output logic          empty
);

    wto_pkg::cmd_t                   slot_reg [wto_pkg::CQ_DEPTH];
    logic [wto_pkg::CQ_PTR_W-1:0]    wptr_reg, wptr_next;
    logic [wto_pkg::CQ_PTR_W-1:0]    rptr_reg, rptr_next;
    logic [wto_pkg::CQ_CNT_W-1:0]    count_reg, count_next;

    assign full     = (count_reg == wto_pkg::CQ_CNT_W'(wto_pkg::CQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = wptr_reg + wto_pkg::CQ_PTR_W'(1);
        end
        if (pop) begin
            rptr_next = rptr_reg + wto_pkg::CQ_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + wto_pkg::CQ_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - wto_pkg::CQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

/* src/wto_front.sv */
// front end: config registers, phase accumulator and command decode
module wto_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,
    input  logic [1:0]                         s_tuser,
    input  logic                               cfg_wr_en,
    input  logic [wto_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wto_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               cq_full,
    output logic                               cq_push,
    output wto_pkg::cmd_t                      cq_data
);

    logic [wto_pkg::ACC_W-1:0]   step_reg, step_next;
    logic [wto_pkg::IPART_W-1:0] len_reg, len_next;
    logic [wto_pkg::ACC_W-1:0]   acc_reg, acc_next;

    logic                          accept;
    logic [wto_pkg::ACC_W:0]       sum;
    logic [wto_pkg::IPART_W:0]     ipart;
    logic [wto_pkg::IPART_W:0]     ipart_wrapped;
    logic [wto_pkg::ACC_W-1:0]     acc_tick;

    assign s_tready = !cq_full;
    assign accept   = s_tvalid && s_tready;

    // add step, fold the integer part back by one table length at most
    always_comb begin
        sum   = {1'b0, acc_reg} + {1'b0, step_reg};
        ipart = sum[wto_pkg::ACC_W:wto_pkg::FRAC_W];
        if (ipart >= {1'b0, len_reg}) begin
            ipart_wrapped = ipart - {1'b0, len_reg};
        end else begin
            ipart_wrapped = ipart;
        end
        acc_tick = {ipart_wrapped[wto_pkg::IPART_W-1:0], sum[wto_pkg::FRAC_W-1:0]};
    end

    always_comb begin
        step_next    = step_reg;
        len_next     = len_reg;
        acc_next     = acc_reg;
        cq_push      = 1'b0;
        cq_data.kind = wto_pkg::CMD_LOAD;
        cq_data.addr = s_tdata[9:0];
        cq_data.data = s_tdata[17:10];
        if (cfg_wr_en) begin
            unique case (cfg_index)
                wto_pkg::REG_PHASE_STEP:   step_next = cfg_wdata;
                wto_pkg::REG_TABLE_LENGTH: len_next  = cfg_wdata[wto_pkg::IPART_W-1:0];
                default: ;
            endcase
        end
        if (accept) begin
            unique case (s_tuser)
                wto_pkg::OP_TICK: begin
                    acc_next     = acc_tick;
                    cq_push      = 1'b1;
                    cq_data.kind = wto_pkg::CMD_TICK;
                    cq_data.addr = acc_tick[wto_pkg::ACC_W-1:wto_pkg::FRAC_W];
                    cq_data.data = acc_tick[wto_pkg::FRAC_W-1:wto_pkg::FRAC_W-8];
                end
                wto_pkg::OP_LOAD: begin
                    cq_push = 1'b1;
                end
                wto_pkg::OP_PHASE_RST: begin
                    acc_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            len_reg  <= wto_pkg::LENGTH_RESET;
            acc_reg  <= '0;
        end else begin
            step_reg <= step_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

/* src/wto_back.sv */
// back end: table memory, two-read interpolation and result buffer
module wto_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cq_empty,
    input  wto_pkg::cmd_t cq_data,
    output logic          cq_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata
);

    typedef enum logic [1:0] {
        ST_ISSUE  = 2'b01,
        ST_READ_B = 2'b10
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [wto_pkg::ADDR_W-1:0]  addr_b_reg, addr_b_next;
    logic [7:0]                  f_reg, f_next;
    logic signed [7:0]           a_reg;
    logic                        rb_vld_reg, rb_vld_next;
    logic                        prod_vld_reg;
    logic signed [16:0]          pa_reg, pb_reg;

    logic                        ram_en, ram_we;
    logic [wto_pkg::ADDR_W-1:0]  ram_addr;
    logic [7:0]                  ram_rdata;

    logic [7:0]                       out_slot_reg [wto_pkg::OUT_DEPTH];
    logic [wto_pkg::OUT_PTR_W-1:0]    out_wptr_reg, out_rptr_reg;
    logic [wto_pkg::OUT_CNT_W-1:0]    out_count_reg;
    logic                             out_pop;

    logic [wto_pkg::OUT_CNT_W:0]      reserved;
    logic                             can_tick;
    logic                             is_tick;
    logic signed [16:0]               a_ext, b_ext, wa_ext, wb_ext;
    logic signed [17:0]               sum;

    wto_ram #(
        .WIDTH(8),
        .DEPTH(wto_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cq_data.data),
        .rdata (ram_rdata)
    );

    // result slots already taken plus ticks still in the pipe
    always_comb begin
        reserved = (wto_pkg::OUT_CNT_W+1)'(out_count_reg)
                 + (wto_pkg::OUT_CNT_W+1)'(state_reg == ST_READ_B)
                 + (wto_pkg::OUT_CNT_W+1)'(rb_vld_reg)
                 + (wto_pkg::OUT_CNT_W+1)'(prod_vld_reg);
        can_tick = (reserved < (wto_pkg::OUT_CNT_W+1)'(wto_pkg::OUT_DEPTH));
        is_tick  = (cq_data.kind == wto_pkg::CMD_TICK);
    end

    always_comb begin
        state_next  = state_reg;
        addr_b_next = addr_b_reg;
        f_next      = f_reg;
        rb_vld_next = 1'b0;
        cq_pop      = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = wto_pkg::to_addr(cq_data.addr);
        unique case (state_reg)
            ST_ISSUE: begin
                if (!cq_empty && (!is_tick || can_tick)) begin
                    cq_pop = 1'b1;
                    ram_en = 1'b1;
                    ram_we = !is_tick;
                    if (is_tick) begin
                        addr_b_next = wto_pkg::next_addr(cq_data.addr);
                        f_next      = cq_data.data;
                        state_next  = ST_READ_B;
                    end
                end
            end
            ST_READ_B: begin
                ram_en      = 1'b1;
                ram_addr    = addr_b_reg;
                rb_vld_next = 1'b1;
                state_next  = ST_ISSUE;
            end
            default: begin
                state_next = ST_ISSUE;
            end
        endcase
    end

    always_comb begin
        a_ext  = 17'(a_reg);
        b_ext  = 17'($signed(ram_rdata));
        wa_ext = $signed({9'b0, wto_pkg::WEIGHT_MAX - f_reg});
        wb_ext = $signed({9'b0, f_reg});
        sum    = {pa_reg[16], pa_reg} + {pb_reg[16], pb_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_ISSUE;
            rb_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rb_vld_reg   <= rb_vld_next;
            prod_vld_reg <= rb_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        addr_b_reg <= addr_b_next;
        f_reg      <= f_next;
        if (state_reg == ST_READ_B) begin
            a_reg <= $signed(ram_rdata);
        end
        if (rb_vld_reg) begin
            pa_reg <= a_ext * wa_ext;
            pb_reg <= b_ext * wb_ext;
        end
    end

    // result buffer
    assign m_tvalid = (out_count_reg != '0);
    assign m_tdata  = out_slot_reg[out_rptr_reg];
    assign out_pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_wptr_reg  <= '0;
            out_rptr_reg  <= '0;
            out_count_reg <= '0;
        end else begin
            if (prod_vld_reg) begin
                out_wptr_reg <= out_wptr_reg + wto_pkg::OUT_PTR_W'(1);
            end
            if (out_pop) begin
                out_rptr_reg <= out_rptr_reg + wto_pkg::OUT_PTR_W'(1);
            end
            if (prod_vld_reg && !out_pop) begin
                out_count_reg <= out_count_reg + wto_pkg::OUT_CNT_W'(1);
            end else if (out_pop && !prod_vld_reg) begin
                out_count_reg <= out_count_reg - wto_pkg::OUT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_vld_reg) begin
            out_slot_reg[out_wptr_reg] <= sum[15:8];
        end
    end

endmodule

/* src/wavetable_interp_oscillator_top.sv */
// Wavetable oscillator with linear interpolation. The input side takes one word per cycle
// while its four-entry command queue has room; tuser carries the op (tick, table load,
// phase reset). Phase accumulation happens as the word is taken, so ticks and loads leave
// the front end in order. The back end makes two reads of the single-port table memory per
// tick (sample at the phase and the next one), the second in its read-b state, and one
// write per load; phase resets cost nothing there. It takes no new command while a tick's
// second read is pending. Results wait in a four-word buffer, so a stalled output does not
// stop the input until the queues fill. The table has no reset: load every entry that a
// tick can read, including the guard sample at index table_length, first.
module wavetable_interp_oscillator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // entry_address[9:0], entry_value[17:10]
    input  logic [1:0]                     s_tuser,   // op[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // sample_out[7:0]
    input  logic                           cfg_wr_en,
    input  logic [wto_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wto_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic          cq_push;
    logic          cq_pop;
    logic          cq_full;
    logic          cq_empty;
    wto_pkg::cmd_t cq_in;
    wto_pkg::cmd_t cq_out;

    wto_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cq_full   (cq_full),
        .cq_push   (cq_push),
        .cq_data   (cq_in)
    );

    wto_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cq_push),
        .push_data (cq_in),
        .full      (cq_full),
        .pop       (cq_pop),
        .pop_data  (cq_out),
        .empty     (cq_empty)
    );

    wto_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cq_empty (cq_empty),
        .cq_data  (cq_out),
        .cq_pop   (cq_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* src/wto_checker.sv */
// port-level checks of the oscillator, bound to the top level
`include "assert_macros.svh"

module wto_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    `WTO_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")
    `WTO_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result word changed while stalled")
    `WTO_ASSERT_ALWAYS(a_reset_no_out, aclk, $rose(aresetn) |-> !m_tvalid, "result pending right after reset")
    `WTO_ASSERT_ALWAYS(a_reset_ready, aclk, $rose(aresetn) |-> s_tready, "input not ready right after reset")

endmodule

bind wavetable_interp_oscillator_top wto_checker u_checker (.*);
